/* design/mch_pkg.sv */
// Shared constants, widths and the CORDIC angle table for the compass heading block.
// Depends on nothing; used by design/magnetometer_compass_heading.sv.
`timescale 1ns / 1ps

package mch_pkg;

	// Field widths
	localparam int unsigned SAMPLE_W  = 16;
	localparam int unsigned HEADING_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;

	// Internal datapath widths: corrected axis, CORDIC vector, angle accumulator
	localparam int unsigned CORR_W    = 17;
	localparam int unsigned XY_W      = 44;
	localparam int unsigned XY_SHIFT  = 24;
	localparam int unsigned ACC_W     = 27;
	localparam int unsigned ANGLE_W   = 22;
	localparam int unsigned ROUND_SH  = 9;

	localparam int unsigned CORDIC_STAGES_DEF = 16;
	localparam int unsigned ANGLE_TABLE_LEN   = 24;

	// Reset values of the hard-iron offsets
	localparam logic signed [CFG_W-1:0] OFFSET_X_RST = -16'sd270;
	localparam logic signed [CFG_W-1:0] OFFSET_Y_RST = -16'sd425;

	// Start angle for the left half-plane: 180 degrees times 65536
	localparam logic signed [ACC_W-1:0] ACC_HALF_TURN = 27'sd11796480;
	localparam logic signed [ACC_W-1:0] ACC_ROUND     = 27'sd256;

	localparam logic signed [ACC_W-ROUND_SH-1:0] HEADING_LIMIT = 18'sd23040;

	// Register indexes of the configuration channel
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;

	// atan(2^-i) in degrees times 65536, rounded
	function automatic logic [ANGLE_W-1:0] cordic_angle(input int unsigned i);
		logic [ANGLE_W-1:0] a;
		case (i)
			0:       a = 22'd2949120;
			1:       a = 22'd1740967;
			2:       a = 22'd919879;
			3:       a = 22'd466945;
			4:       a = 22'd234379;
			5:       a = 22'd117304;
			6:       a = 22'd58666;
			7:       a = 22'd29335;
			8:       a = 22'd14668;
			9:       a = 22'd7334;
			10:      a = 22'd3667;
			11:      a = 22'd1833;
			12:      a = 22'd917;
			13:      a = 22'd458;
			14:      a = 22'd229;
			15:      a = 22'd115;
			16:      a = 22'd57;
			17:      a = 22'd29;
			18:      a = 22'd14;
			19:      a = 22'd7;
			20:      a = 22'd4;
			21:      a = 22'd2;
			22:      a = 22'd1;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

/* design/magnetometer_compass_heading.sv */
// Top level of the compass heading block: offset correction and a pipelined CORDIC atan2.
// Depends on design/mch_pkg.sv for widths, reset offsets and the angle table.
`timescale 1ns / 1ps

// Usage
//   Input stream s_*: one magnetometer sample per request, tdata packs mag_x, mag_y and
//   mag_z (16 bits each, signed). mag_z is accepted and ignored.
//   Output stream m_*: one result per sample, in order. tdata holds the heading in
//   degrees times 128 (signed, -180..+180), tuser holds the invalid flag, set when the
//   corrected X and Y are both zero (heading then reads 0).
//   Config channel cfg_*: index 0 writes offset_x, index 1 writes offset_y; other
//   indexes are ignored. cfg_ready is always high. Write only while the pipe is empty.
// Timing
//   A sample passes CORDIC_STAGES + 3 register stages: one for the offset subtraction,
//   one for the half-plane fold, one per CORDIC iteration and one for rounding and
//   clamping. One sample is taken every cycle unless the receiver stalls the pipe.
// Reset and stall
//   arst_n clears every valid bit and restores the offsets to -270 and -425.
//   Each stage holds while its successor is full and stalled, so a stalled receiver
//   backs the pipe up stage by stage; bubbles are squeezed out, nothing is lost or
//   repeated, and s_tready stays high while any stage ahead still has room.
module magnetometer_compass_heading #(
	parameter int unsigned CORDIC_STAGES = mch_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Sample stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [3*mch_pkg::SAMPLE_W-1:0]      s_tdata,   // mag_x, mag_y, mag_z
	// Heading stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mch_pkg::HEADING_W-1:0]       m_tdata,   // heading
	output logic                                m_tuser,   // invalid
	// Configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mch_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mch_pkg::CFG_W-1:0]           cfg_data
);

	localparam int unsigned SW  = mch_pkg::SAMPLE_W;
	localparam int unsigned CW  = mch_pkg::CORR_W;
	localparam int unsigned XW  = mch_pkg::XY_W;
	localparam int unsigned AW  = mch_pkg::ACC_W;
	localparam int unsigned HW  = mch_pkg::HEADING_W;
	localparam int unsigned RW  = AW - mch_pkg::ROUND_SH;
	localparam int unsigned NST = CORDIC_STAGES;

	// Configuration registers
	logic signed [mch_pkg::CFG_W-1:0] offset_x_q, offset_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= mch_pkg::OFFSET_X_RST;
			offset_y_q <= mch_pkg::OFFSET_Y_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				mch_pkg::CFG_OFFSET_X: offset_x_q <= cfg_data;
				mch_pkg::CFG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage handshake: a stage loads when it is empty or its successor takes its item
	logic            valid_s1, valid_s2, valid_s4;
	logic            ready_s1, ready_s2, ready_s4;
	logic [NST-1:0]  valid_s3, ready_s3;

	assign ready_s4 = !valid_s4 || m_tready;
	assign ready_s3[NST-1] = !valid_s3[NST-1] || ready_s4;
	for (genvar k = 0; k < NST - 1; k++) begin : g_ready
		assign ready_s3[k] = !valid_s3[k] || ready_s3[k+1];
	end
	assign ready_s2 = !valid_s2 || ready_s3[0];
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;

	// Stage 1: remove the hard-iron offsets at 17 bits
	logic signed [SW-1:0] mag_x, mag_y;
	logic signed [CW-1:0] cx_s1, cy_s1;

	assign mag_x = s_tdata[SW-1:0];
	assign mag_y = s_tdata[2*SW-1:SW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			cx_s1 <= CW'(mag_x) - CW'(offset_x_q);
			cy_s1 <= CW'(mag_y) - CW'(offset_y_q);
		end
	end

	// Stage 2: scale up, fold the left half-plane onto the right, seed the angle
	logic signed [XW-1:0] x_scaled, y_scaled;
	logic signed [XW-1:0] x_s2, y_s2;
	logic signed [AW-1:0] acc_s2;
	logic                 zero_s2;

	assign x_scaled = XW'(cx_s1) <<< mch_pkg::XY_SHIFT;
	assign y_scaled = XW'(cy_s1) <<< mch_pkg::XY_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			zero_s2 <= (cx_s1 == '0) && (cy_s1 == '0);
			if (cx_s1 < 0) begin
				x_s2   <= -x_scaled;
				y_s2   <= -y_scaled;
				acc_s2 <= (cy_s1 >= 0) ? mch_pkg::ACC_HALF_TURN : -mch_pkg::ACC_HALF_TURN;
			end else begin
				x_s2   <= x_scaled;
				y_s2   <= y_scaled;
				acc_s2 <= '0;
			end
		end
	end

	// Stage 3: one vectoring iteration per register stage
	logic signed [XW-1:0] x_s3   [NST];
	logic signed [XW-1:0] y_s3   [NST];
	logic signed [AW-1:0] acc_s3 [NST];
	logic        [NST-1:0] zero_s3;

	for (genvar k = 0; k < NST; k++) begin : g_cordic
		localparam logic [AW-1:0] ANGLE = AW'(mch_pkg::cordic_angle(k));

		logic signed [XW-1:0] x_in, y_in;
		logic signed [AW-1:0] acc_in;
		logic                 zero_in, valid_in;

		if (k == 0) begin : g_first
			assign x_in     = x_s2;
			assign y_in     = y_s2;
			assign acc_in   = acc_s2;
			assign zero_in  = zero_s2;
			assign valid_in = valid_s2;
		end else begin : g_next
			assign x_in     = x_s3[k-1];
			assign y_in     = y_s3[k-1];
			assign acc_in   = acc_s3[k-1];
			assign zero_in  = zero_s3[k-1];
			assign valid_in = valid_s3[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s3[k] <= 1'b0;
			end else if (ready_s3[k]) begin
				valid_s3[k] <= valid_in;
			end
		end

		// Rotate towards the X axis; both updates use the incoming vector
		always_ff @(posedge clk) begin
			if (ready_s3[k] && valid_in) begin
				zero_s3[k] <= zero_in;
				if (y_in >= 0) begin
					x_s3[k]   <= x_in + (y_in >>> k);
					y_s3[k]   <= y_in - (x_in >>> k);
					acc_s3[k] <= acc_in + ANGLE;
				end else begin
					x_s3[k]   <= x_in - (y_in >>> k);
					y_s3[k]   <= y_in + (x_in >>> k);
					acc_s3[k] <= acc_in - ANGLE;
				end
			end
		end
	end

	// Stage 4: round to 7 fraction bits, clamp to +-180 degrees, flag the zero vector
	logic signed [AW-1:0] acc_rnd;
	logic signed [RW-1:0] head_full;
	logic signed [HW-1:0] head_clamped;
	logic signed [HW-1:0] heading_s4;
	logic                 invalid_s4;

	assign acc_rnd   = acc_s3[NST-1] + mch_pkg::ACC_ROUND;
	assign head_full = acc_rnd[AW-1:mch_pkg::ROUND_SH];

	always_comb begin
		if (head_full > mch_pkg::HEADING_LIMIT) begin
			head_clamped = HW'(mch_pkg::HEADING_LIMIT);
		end else if (head_full < -mch_pkg::HEADING_LIMIT) begin
			head_clamped = HW'(-mch_pkg::HEADING_LIMIT);
		end else begin
			head_clamped = head_full[HW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ready_s4) begin
			valid_s4 <= valid_s3[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s3[NST-1]) begin
			invalid_s4 <= zero_s3[NST-1];
			heading_s4 <= zero_s3[NST-1] ? '0 : head_clamped;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = heading_s4;
	assign m_tuser  = invalid_s4;

endmodule
